>>> src/tedet_pkg.sv
// Package: shared state type, encoding codes and byte constants of the text encoding detector.
package tedet_pkg;

	// Encoding result codes.
	localparam logic [2:0] ENC_U16BE_MARK = 3'd0;
	localparam logic [2:0] ENC_U16LE_MARK = 3'd1;
	localparam logic [2:0] ENC_UTF8_MARK  = 3'd2;
	localparam logic [2:0] ENC_U16BE_BARE = 3'd3;
	localparam logic [2:0] ENC_UTF8       = 3'd4;
	localparam logic [2:0] ENC_ASCII7     = 3'd5;
	localparam logic [2:0] ENC_8BIT       = 3'd6;

	// Byte-order mark bytes.
	localparam logic [7:0] BOM_U8_0  = 8'hEF;
	localparam logic [7:0] BOM_U8_1  = 8'hBB;
	localparam logic [7:0] BOM_U8_2  = 8'hBF;
	localparam logic [7:0] BOM_U16_HI = 8'hFE;
	localparam logic [7:0] BOM_U16_LO = 8'hFF;
	localparam logic [7:0] BYTE_NUL   = 8'h00;

	// Continuation byte pattern 10xxxxxx.
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_VALUE = 8'h80;

	// Number of leading bytes kept for the mark tests.
	localparam int unsigned HEAD_DEPTH = 3;

	typedef struct packed {
		logic [HEAD_DEPTH-1:0][7:0] head;        // first bytes of the buffer
		logic [1:0]                 bytes_seen;  // saturates at three
		logic                       all_seven;   // still pure 7-bit ASCII
		logic                       utf8_good;   // UTF-8 scan has not failed
		logic                       stopped;     // scan ended early
		logic [1:0]                 cont_left;   // continuation bytes owed
		logic                       seq_bad;     // current sequence has a bad byte
	} scan_state_t;

	localparam scan_state_t STATE_RESET = '{
		head:       '0,
		bytes_seen: 2'd0,
		all_seven:  1'b1,
		utf8_good:  1'b1,
		stopped:    1'b0,
		cont_left:  2'd0,
		seq_bad:    1'b0
	};

endpackage

>>> src/tedet_scan.sv
// Next-state logic: head byte capture and one step of the UTF-8 scan.
module tedet_scan (
	input  logic [7:0]            data_byte,
	input  tedet_pkg::scan_state_t cur,
	output tedet_pkg::scan_state_t nxt
);
	import tedet_pkg::*;

	logic       cont_ok;
	logic [1:0] cont_dec;
	logic       bad_now;

	assign cont_ok  = (data_byte & CONT_MASK) == CONT_VALUE;
	assign cont_dec = cur.cont_left - 2'd1;
	assign bad_now  = cur.seq_bad | ~cont_ok;

	always_comb begin
		nxt = cur;

		// Keep the first three bytes for the mark tests.
		if (cur.bytes_seen != 2'd3) begin
			nxt.head[cur.bytes_seen] = data_byte;
			nxt.bytes_seen = cur.bytes_seen + 2'd1;
		end

		if (!cur.stopped) begin
			if (cur.cont_left != 2'd0) begin
				// Continuation bytes are judged together when the sequence ends.
				nxt.seq_bad   = bad_now;
				nxt.cont_left = cont_dec;
				if (cont_dec == 2'd0 && bad_now) begin
					nxt.utf8_good = 1'b0;
					nxt.stopped   = 1'b1;
				end
			end else begin
				case (data_byte) inside
					[8'h01:8'h7F]: begin
					end
					[8'hC0:8'hDF]: begin
						nxt.all_seven = 1'b0;
						nxt.cont_left = 2'd1;
						nxt.seq_bad   = 1'b0;
					end
					[8'hE0:8'hEF]: begin
						nxt.all_seven = 1'b0;
						nxt.cont_left = 2'd2;
						nxt.seq_bad   = 1'b0;
					end
					default: begin
						// NUL, stray continuation or a lead of F0 and above.
						nxt.all_seven = 1'b0;
						nxt.utf8_good = 1'b0;
						nxt.stopped   = 1'b1;
					end
				endcase
			end
		end
	end

endmodule

>>> src/tedet_classify.sv
// Final classification of a buffer from its scan state.
module tedet_classify (
	input  tedet_pkg::scan_state_t st,
	output logic [2:0]             encoding
);
	import tedet_pkg::*;

	logic two_plus;
	logic three;

	assign two_plus = st.bytes_seen > 2'd1;
	assign three    = st.bytes_seen == 2'd3;

	always_comb begin
		if (two_plus && st.head[0] == BOM_U16_HI && st.head[1] == BOM_U16_LO) begin
			encoding = ENC_U16BE_MARK;
		end else if (two_plus && st.head[0] == BOM_U16_LO && st.head[1] == BOM_U16_HI) begin
			encoding = ENC_U16LE_MARK;
		end else if (three && st.head[0] == BOM_U8_0 && st.head[1] == BOM_U8_1
				&& st.head[2] == BOM_U8_2) begin
			encoding = ENC_UTF8_MARK;
		end else if (two_plus && st.head[0] == BYTE_NUL && st.head[1] != BYTE_NUL) begin
			encoding = ENC_U16BE_BARE;
		end else if (st.all_seven) begin
			encoding = ENC_ASCII7;
		end else if (st.utf8_good) begin
			encoding = ENC_UTF8;
		end else begin
			encoding = ENC_8BIT;
		end
	end

endmodule

>>> src/text_encoding_detector.sv
// Top level of the text encoding detector: input register, scan state and result register.
// The detector takes a text buffer one byte per beat on the input channel, with last_byte
// high on the final byte, and delivers one encoding beat per buffer: a byte-order mark
// (UTF-16 BE, UTF-16 LE, UTF-8) if the buffer opens with one, UTF-16 BE without a mark if
// it opens with a NUL and then a non-NUL byte, and otherwise 7-bit ASCII, UTF-8 or 8-bit
// text as decided by a running UTF-8 scan. A byte is taken every clock cycle unless a final
// byte waits in the input register, and a buffer's result is written to the result register
// when its final byte leaves the input register.
// Each byte passes through one input register, and the scan update and classification sit
// in combinational compares between that register and the scan state and result
// registers. While a result waits on the output the detector keeps taking bytes; only the
// final byte of a following buffer is held in the input register until the waiting result
// is taken. After each final byte the scan state returns to its reset values, so buffers
// follow each other without gaps.
module text_encoding_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] encoding
);
	import tedet_pkg::*;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Scan state and result register.
	scan_state_t state_q;
	scan_state_t state_next;
	logic        out_valid_q;
	logic [2:0]  encoding_q;
	logic [2:0]  encoding_next;

	logic        out_free;
	logic        adv_s1;
	logic        take_in;

	// A non-final byte never produces a result, so it always moves on; a final byte needs
	// the result register to be free or emptied in this cycle.
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;
	assign take_in  = in_valid && in_ready;

	tedet_scan u_scan (
		.data_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_next)
	);

	tedet_classify u_classify (
		.st       (state_next),
		.encoding (encoding_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// The scan state is cleared after a final byte, ready for the next buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv_s1) begin
			state_q <= last_s1 ? STATE_RESET : state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			encoding_q <= encoding_next;
		end
	end

	assign out_valid = out_valid_q;
	assign encoding  = encoding_q;

endmodule

>>> src/tedet_checker.sv
// Port-level checker for the text encoding detector, bound to its top level.
module tedet_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] encoding
);
	import tedet_pkg::*;

	// Final bytes taken whose result has not yet been delivered.
	logic [1:0] pending_q;
	logic       last_in;
	logic       res_out;

	assign last_in = in_valid && in_ready && last_byte;
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= pending_q + {1'b0, last_in} - {1'b0, res_out};
		end
	end

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result shown without a pending final byte");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more than two buffers pending");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 2'd2 && !out_ready) |-> !in_ready)
		else $error("input taken while both result slots are full");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(encoding)))
		else $error("stalled result changed or dropped");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> encoding <= ENC_8BIT)
		else $error("encoding outside the defined codes");

endmodule

bind text_encoding_detector tedet_checker u_tedet_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last_byte (last_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.encoding  (encoding)
);

>>> tb/sv/tb_text_encoding_detector.sv
// Self-checking testbench for the text encoding detector: directed buffers, then random ones.
`timescale 1ns / 100ps

module tb_text_encoding_detector;
	import tedet_pkg::*;

	// Rough number of bytes to send; after QUIET_FROM bytes neither side idles any more.
	localparam int BYTE_TARGET  = 1850;
	localparam int QUIET_FROM   = 1550;
	// Cycles without any beat before the run is declared hung.
	localparam int HANG_LIMIT   = 1000;
	// Cycles to keep watching the output after the last expected encoding has arrived.
	localparam int DRAIN_CYCLES = 8;
	// Marks a directed row whose encoding is left to the predictor.
	localparam logic [2:0] NO_ENC = 3'd7;

	// One row of the directed table: the byte, its last flag and, where it is obvious,
	// the encoding the buffer must get.
	typedef struct packed {
		logic [7:0] value;
		logic       fin;
		logic       typed;
		logic [2:0] enc;
	} byte_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] encoding;

	text_encoding_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.encoding  (encoding)
	);

	always #4 clk = ~clk;

	// Predictor state: a private copy of the detector's scan state.
	logic [7:0] lead_bytes [0:2];
	logic [1:0] lead_count;
	logic       seven_bit;
	logic       utf8_ok;
	logic       scan_done;
	logic [1:0] cont_owed;
	logic       seq_broken;

	// Encodings predicted for buffers whose final byte has gone in, oldest first.
	logic [2:0] pending_enc [$];
	// Bytes of the random buffer being sent.
	logic [7:0] buffer_bytes [$];
	byte_row_t  directed_rows [0:23];

	int error_count     = 0;
	int buffers_sent    = 0;
	int bytes_sent      = 0;
	int results_checked = 0;
	int quiet_cycles    = 0;
	int enc_hits [0:6]  = '{default: 0};
	// Chance in percent that the sender idles before a beat, and that the receiver stalls.
	int gap_pct         = 0;
	int stall_pct       = 0;

	task automatic report_mismatch(input string what);
		error_count++;
		$display("t=%0t MISMATCH: %s", $time, what);
	endtask

	task automatic clear_detector();
		lead_bytes = '{default: 8'h00};
		lead_count = 2'd0;
		seven_bit  = 1'b1;
		utf8_ok    = 1'b1;
		scan_done  = 1'b0;
		cont_owed  = 2'd0;
		seq_broken = 1'b0;
	endtask

	// Mark tests come first, in priority order; only then does the UTF-8 scan decide.
	function automatic logic [2:0] classify_buffer();
		if (lead_count > 2'd1 && lead_bytes[0] == BOM_U16_HI && lead_bytes[1] == BOM_U16_LO)
			return ENC_U16BE_MARK;
		if (lead_count > 2'd1 && lead_bytes[0] == BOM_U16_LO && lead_bytes[1] == BOM_U16_HI)
			return ENC_U16LE_MARK;
		if (lead_count > 2'd2 && lead_bytes[0] == BOM_U8_0 && lead_bytes[1] == BOM_U8_1 &&
				lead_bytes[2] == BOM_U8_2)
			return ENC_UTF8_MARK;
		if (lead_count > 2'd1 && lead_bytes[0] == BYTE_NUL && lead_bytes[1] != BYTE_NUL)
			return ENC_U16BE_BARE;
		if (seven_bit)
			return ENC_ASCII7;
		if (utf8_ok)
			return ENC_UTF8;
		return ENC_8BIT;
	endfunction

	// Advances the predictor by one byte. On the final byte it returns the buffer's
	// encoding and clears the state for the next buffer.
	task automatic step_detector(input logic [7:0] value, input logic fin,
			output logic [2:0] enc);
		enc = NO_ENC;
		if (lead_count < 2'd3) begin
			lead_bytes[lead_count] = value;
			lead_count = lead_count + 2'd1;
		end
		if (!scan_done) begin
			if (cont_owed != 2'd0) begin
				// Continuation bytes are only judged once the whole sequence is in.
				if ((value & CONT_MASK) != CONT_VALUE)
					seq_broken = 1'b1;
				cont_owed = cont_owed - 2'd1;
				if (cont_owed == 2'd0 && seq_broken) begin
					utf8_ok   = 1'b0;
					scan_done = 1'b1;
				end
			end else if (value == BYTE_NUL || (value >= 8'h80 && value < 8'hC0) ||
					value >= 8'hF0) begin
				// NUL, a stray continuation byte or a lead of F0 or above ends the scan.
				seven_bit = 1'b0;
				utf8_ok   = 1'b0;
				scan_done = 1'b1;
			end else if (value >= 8'hC0) begin
				seven_bit  = 1'b0;
				cont_owed  = (value < 8'hE0) ? 2'd1 : 2'd2;
				seq_broken = 1'b0;
			end
		end
		if (fin) begin
			// Bytes still owed by a cut-off sequence are simply forgotten here.
			enc = classify_buffer();
			clear_detector();
		end
	endtask

	// Presents one beat at a falling edge and returns at the falling edge after it was
	// taken. A random idle burst may come first.
	task automatic send_byte(input logic [7:0] value, input logic fin, input logic typed,
			input logic [2:0] typed_enc);
		logic [2:0] predicted;
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= value;
		last_byte <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		step_detector(value, fin, predicted);
		if (fin) begin
			pending_enc.push_back(typed ? typed_enc : predicted);
			buffers_sent++;
		end
		bytes_sent++;
		@(negedge clk);
	endtask

	// Holds the input side quiet until every outstanding encoding has been delivered.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_enc.size() != 0)
			@(negedge clk);
	endtask

	// Appends one well-formed UTF-8 character. With cut set, a multi-byte character loses
	// part of its tail, which only makes sense as the last character of a buffer.
	task automatic push_char(input bit cut);
		int width;
		int tail;
		case ($urandom_range(0, 3))
			0, 1: width = 1;
			2: width = 2;
			default: width = 3;
		endcase
		if (width == 1) begin
			buffer_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
		end else begin
			if (width == 2)
				buffer_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
			else
				buffer_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
			tail = cut ? $urandom_range(0, width - 2) : width - 1;
			repeat (tail)
				buffer_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
		end
	endtask

	// Builds one random buffer. Most buffers are well-formed text, some with a leading
	// mark (sometimes cut short) or a leading NUL; the rest carry a corrupted byte or are pure noise.
	task automatic build_buffer();
		int kind;
		int chars;
		int spot;
		buffer_bytes.delete();
		kind  = $urandom_range(0, 99);
		chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
		if (kind < 8) begin
			buffer_bytes.push_back(BOM_U16_HI);
			buffer_bytes.push_back(BOM_U16_LO);
		end else if (kind < 16) begin
			buffer_bytes.push_back(BOM_U16_LO);
			buffer_bytes.push_back(BOM_U16_HI);
		end else if (kind < 26) begin
			buffer_bytes.push_back(BOM_U8_0);
			buffer_bytes.push_back(BOM_U8_1);
			buffer_bytes.push_back(BOM_U8_2);
		end else if (kind < 34) begin
			buffer_bytes.push_back(BYTE_NUL);
			if ($urandom_range(0, 3) == 0)
				buffer_bytes.push_back(BYTE_NUL);
			else
				buffer_bytes.push_back(8'($urandom_range(8'h01, 8'hFF)));
		end
		// A partial mark must fall through to the later tests and the scan.
		if (kind < 26 && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, buffer_bytes.size() - 1))
				void'(buffer_bytes.pop_back());
		if (kind >= 92) begin
			repeat (chars)
				buffer_bytes.push_back(8'($urandom()));
		end else if (kind >= 34 && kind < 44) begin
			repeat (chars)
				buffer_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
		end else begin
			repeat (chars)
				push_char(1'b0);
			if ($urandom_range(0, 3) == 0)
				push_char(1'b1);
		end
		if (kind >= 80 && kind < 92 && buffer_bytes.size() != 0) begin
			spot = $urandom_range(0, buffer_bytes.size() - 1);
			buffer_bytes[spot] = 8'($urandom());
		end
		if (buffer_bytes.size() == 0)
			buffer_bytes.push_back(8'($urandom()));
	endtask

	// Receiver: stalls come in random bursts, changed at falling edges.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Result checker and watchdog, both sampling at the rising edge.
	always @(posedge clk) begin : result_check
		logic [2:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_enc.size() == 0) begin
					report_mismatch($sformatf("encoding %0d delivered with no buffer outstanding",
						encoding));
				end else begin
					want = pending_enc.pop_front();
					if (encoding !== want)
						report_mismatch($sformatf("encoding %0d, expected %0d", encoding, want));
				end
				results_checked++;
				if (!$isunknown(encoding) && encoding <= ENC_8BIT)
					enc_hits[encoding]++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("t=%0t watchdog: no beat for %0d cycles, %0d encodings outstanding",
					$time, quiet_cycles, pending_enc.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase_left;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		phase_left = 0;
		clear_detector();

		// Directed buffers: every mark, a bare UTF-16 BE start, the scan outcomes, each way
		// the scan fails, a cut-off sequence, one-byte buffers and a buffer of the ASCII extremes.
		directed_rows = '{
			{8'h41,      1'b1, 1'b1, ENC_ASCII7},      // one ASCII byte
			{BOM_U16_HI, 1'b0, 1'b0, NO_ENC},
			{BOM_U16_LO, 1'b1, 1'b1, ENC_U16BE_MARK},  // UTF-16 BE mark
			{BOM_U16_LO, 1'b0, 1'b0, NO_ENC},
			{BOM_U16_HI, 1'b1, 1'b1, ENC_U16LE_MARK},  // UTF-16 LE mark
			{BOM_U8_0,   1'b0, 1'b0, NO_ENC},
			{BOM_U8_1,   1'b0, 1'b0, NO_ENC},
			{BOM_U8_2,   1'b1, 1'b1, ENC_UTF8_MARK},   // UTF-8 mark
			{BYTE_NUL,   1'b0, 1'b0, NO_ENC},
			{8'h41,      1'b1, 1'b1, ENC_U16BE_BARE},  // NUL then non-NUL
			{8'hC3,      1'b0, 1'b0, NO_ENC},
			{8'hA9,      1'b1, 1'b0, NO_ENC},          // two-byte character
			{8'hE2,      1'b0, 1'b0, NO_ENC},
			{8'h82,      1'b1, 1'b0, NO_ENC},          // three-byte lead cut off at the end
			{8'hC3,      1'b0, 1'b0, NO_ENC},
			{8'h41,      1'b1, 1'b0, NO_ENC},          // bad continuation byte
			{8'h80,      1'b1, 1'b1, ENC_8BIT},        // stray continuation byte
			{8'hFF,      1'b1, 1'b1, ENC_8BIT},        // lead of F0 or above
			{BYTE_NUL,   1'b1, 1'b1, ENC_8BIT},        // lone NUL
			{8'h7F,      1'b0, 1'b0, NO_ENC},
			{8'h01,      1'b1, 1'b1, ENC_ASCII7},      // ASCII extremes
			{8'hE2,      1'b0, 1'b0, NO_ENC},
			{8'h82,      1'b0, 1'b0, NO_ENC},
			{8'hAC,      1'b1, 1'b0, NO_ENC}           // three-byte character
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_pct   = 25;
		stall_pct = 25;
		foreach (directed_rows[i])
			send_byte(directed_rows[i].value, directed_rows[i].fin, directed_rows[i].typed,
				directed_rows[i].enc);
		// The sender waits here for every directed result before going random.
		drain_results();

		// Random part in phases of 10 to 30 buffers, each with its own idle and stall
		// rates, some with none at all. A phase sometimes opens with a full drain.
		while (bytes_sent < BYTE_TARGET) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 30);
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 10;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 40;
				endcase
				if ($urandom_range(0, 2) == 0)
					drain_results();
			end
			if (bytes_sent >= QUIET_FROM) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			build_buffer();
			foreach (buffer_bytes[i])
				send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1, 1'b0, NO_ENC);
			phase_left--;
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d buffers in %0d bytes; %0d encodings checked, %0d mismatches.",
			buffers_sent, bytes_sent, results_checked, error_count);
		$display("By class: BE mark %0d, LE mark %0d, UTF-8 mark %0d, BE bare %0d, %s %0d, %s",
			enc_hits[ENC_U16BE_MARK], enc_hits[ENC_U16LE_MARK], enc_hits[ENC_UTF8_MARK],
			enc_hits[ENC_U16BE_BARE], "UTF-8", enc_hits[ENC_UTF8],
			$sformatf("ASCII %0d, 8-bit %0d", enc_hits[ENC_ASCII7], enc_hits[ENC_8BIT]));
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
